// ----- design/acl_pkg.sv -----
// Package for the ASCII command line receiver.
// Holds shared types, event and register codes and the keyword table.
// No dependencies.
package acl_pkg;

    localparam int LINE_BUF_SIZE_DEF = 128;
    localparam int KW_COUNT          = 5;
    localparam int TICK_W            = 16;
    localparam int POS_W             = 5;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;

    localparam logic [TICK_W-1:0] PARTIAL_TO_RST = 16'd2000;
    localparam logic [TICK_W-1:0] LINK_TO_RST    = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;
    localparam logic [POS_W-1:0]  POS_MAX        = 5'd31;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        EV_TAKEOFF  = 3'd0,
        EV_LAND     = 3'd1,
        EV_CANCEL   = 3'd2,
        EV_PROGRAM  = 3'd3,
        EV_USER     = 3'd4,
        EV_JSON     = 3'd5,
        EV_FAILSAFE = 3'd6
    } ev_t;

    typedef enum logic [1:0] {
        FC_NONE = 2'd0,
        FC_JSON = 2'd1,
        FC_TEXT = 2'd2
    } fc_t;

    typedef enum logic [0:0] {
        CFG_PARTIAL_TO = 1'b0,
        CFG_LINK_TO    = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        ev_t        event_res;
        logic [6:0] line_len;
        logic       link_up;
    } result_t;

    function automatic logic [POS_W-1:0] kw_len(input logic [2:0] k);
        logic [POS_W-1:0] len;
        case (k)
            EV_TAKEOFF: len = 5'd7;
            EV_LAND:    len = 5'd4;
            EV_CANCEL:  len = 5'd6;
            EV_PROGRAM: len = 5'd15;
            EV_USER:    len = 5'd12;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

    // Character of keyword k at position pos, or zero past its end.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [POS_W-1:0] pos);
        logic [127:0]     txt;
        logic [POS_W-1:0] len;
        logic [3:0]       idx;
        case (k)
            EV_TAKEOFF: txt = "takeoff";
            EV_LAND:    txt = "land";
            EV_CANCEL:  txt = "cancel";
            EV_PROGRAM: txt = {"program", "_control"};
            EV_USER:    txt = {"user", "_control"};
            default:    txt = '0;
        endcase
        len = kw_len(k);
        idx = 4'(len - 5'd1 - pos);
        if (pos >= len)
            return 8'h00;
        return txt[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ----- design/acl_in_stage.sv -----
// Input register of the command line receiver.
// Takes one request per cycle unless stalled, feeds the engine; uses acl_pkg.
module acl_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  acl_pkg::item_t in_item,
    input  logic          advance,
    output logic          item_valid,
    output acl_pkg::item_t item
);
    import acl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

endmodule

// ----- design/acl_engine.sv -----
// Line state, keyword matcher and link supervisor of the receiver.
// Updates all state for one request per cycle while fire is set; uses acl_pkg.
module acl_engine #(
    parameter int LINE_BUF_SIZE = acl_pkg::LINE_BUF_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_addr,
    input  logic [15:0]     cfg_wdata,
    input  logic            fire,
    input  acl_pkg::item_t  item,
    output logic            res_valid,
    output acl_pkg::result_t res
);
    import acl_pkg::*;

    localparam int CW = $clog2(LINE_BUF_SIZE);
    localparam logic [CW:0] BUF_LIMIT = (CW+1)'(LINE_BUF_SIZE);

    logic [TICK_W-1:0] partial_to_reg;
    logic [TICK_W-1:0] link_to_reg;

    logic [CW-1:0]     count_reg,    count_next;
    logic              disc_reg,     disc_next;
    logic [TICK_W-1:0] idle_reg,     idle_next;
    logic              tvalid_reg,   tvalid_next;
    logic              conn_reg,     conn_next;
    logic              ever_reg,     ever_next;
    logic [TICK_W-1:0] sil_reg,      sil_next;
    logic [KW_COUNT-1:0] mask_reg,   mask_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic              tsp_reg,      tsp_next;
    fc_t               fc_reg,       fc_next;

    logic [7:0]        b;
    logic [7:0]        low;
    logic              is_blank;
    logic              valid_start;
    logic              byte_ok;
    logic              timed_out;
    logic [CW-1:0]     cnt0;
    logic              disc0;
    logic [TICK_W-1:0] sil_inc;
    logic [KW_COUNT-1:0] base_mask;
    logic [POS_W-1:0]  base_pos;
    logic              base_tsp;
    fc_t               base_fc;
    fc_t               fc1;
    logic [KW_COUNT-1:0] hit;
    logic              kw_found;
    ev_t               kw_ev;
    logic [CW+6:0]     count_wide;

    assign b        = item.rx_byte;
    assign is_blank = (b == CH_SPACE) || (b == CH_TAB);
    assign valid_start = (b == CH_LBRACE) || (b == CH_LBRACK) ||
                         (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                         (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    assign byte_ok  = (b == CH_TAB) || (b >= CH_SPACE && b <= CH_TILDE);
    assign low      = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;

    assign timed_out = (count_reg != '0) && tvalid_reg && (idle_reg > partial_to_reg);
    assign cnt0      = timed_out ? '0 : count_reg;
    assign disc0     = timed_out ? 1'b0 : disc_reg;
    assign sil_inc   = (ever_reg && sil_reg != TICK_MAX) ? sil_reg + 16'd1 : sil_reg;

    assign base_mask = (cnt0 == '0) ? {KW_COUNT{1'b1}} : mask_reg;
    assign base_pos  = (cnt0 == '0) ? '0 : pos_reg;
    assign base_tsp  = (cnt0 == '0) ? 1'b0 : tsp_reg;
    assign base_fc   = (cnt0 == '0) ? FC_NONE : fc_reg;
    assign fc1       = (base_fc != FC_NONE) ? base_fc :
                       ((b == CH_LBRACE || b == CH_LBRACK) ? FC_JSON : FC_TEXT);

    assign count_wide = (CW+7)'(count_reg);

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
            hit[k] = (kw_char(3'(k), base_pos) == low);
    end

    always_comb
    begin
        kw_found = 1'b0;
        kw_ev    = EV_TAKEOFF;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (mask_reg[k] && kw_len(3'(k)) == pos_reg)
            begin
                kw_found = 1'b1;
                kw_ev    = ev_t'(3'(k));
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        disc_next   = disc_reg;
        idle_next   = idle_reg;
        tvalid_next = tvalid_reg;
        conn_next   = conn_reg;
        ever_next   = ever_reg;
        sil_next    = sil_reg;
        mask_next   = mask_reg;
        pos_next    = pos_reg;
        tsp_next    = tsp_reg;
        fc_next     = fc_reg;
        res_valid   = 1'b0;
        res.event_res = EV_FAILSAFE;
        res.line_len  = '0;
        res.link_up   = 1'b0;
        if (fire)
        begin
            if (item.opcode == OP_TICK)
            begin
                if (tvalid_reg && idle_reg != TICK_MAX)
                    idle_next = idle_reg + 16'd1;
                sil_next = sil_inc;
                if (conn_reg && ever_reg && sil_inc > link_to_reg)
                begin
                    conn_next = 1'b0;
                    res_valid = 1'b1;
                end
            end
            else
            begin
                conn_next = 1'b1;
                ever_next = 1'b1;
                sil_next  = '0;
                if (b != CH_CR)
                begin
                    count_next  = cnt0;
                    disc_next   = disc0;
                    idle_next   = '0;
                    tvalid_next = 1'b1;
                    if (b == CH_LF)
                    begin
                        if (!disc0 && cnt0 != '0)
                        begin
                            res.line_len = count_wide[6:0];
                            res.link_up  = 1'b1;
                            if (fc_reg == FC_JSON)
                            begin
                                res_valid     = 1'b1;
                                res.event_res = EV_JSON;
                            end
                            else if (fc_reg == FC_TEXT && kw_found)
                            begin
                                res_valid     = 1'b1;
                                res.event_res = kw_ev;
                            end
                        end
                        count_next  = '0;
                        disc_next   = 1'b0;
                        tvalid_next = 1'b0;
                    end
                    else if (!disc0)
                    begin
                        if (cnt0 == '0 && !valid_start)
                            disc_next = 1'b1;
                        else if (!byte_ok)
                        begin
                            count_next = '0;
                            disc_next  = 1'b1;
                        end
                        else if ((CW+1)'(cnt0) + 1'b1 < BUF_LIMIT)
                        begin
                            count_next = cnt0 + 1'b1;
                            mask_next  = base_mask;
                            pos_next   = base_pos;
                            tsp_next   = base_tsp;
                            fc_next    = base_fc;
                            if (!(base_fc == FC_NONE && is_blank))
                            begin
                                fc_next = fc1;
                                if (fc1 == FC_TEXT)
                                begin
                                    if (is_blank)
                                        tsp_next = 1'b1;
                                    else if (base_tsp)
                                        mask_next = '0;
                                    else
                                    begin
                                        mask_next = base_mask & hit;
                                        if (base_pos != POS_MAX)
                                            pos_next = base_pos + 1'b1;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            count_next = '0;
                            disc_next  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_to_reg <= PARTIAL_TO_RST;
            link_to_reg    <= LINK_TO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_PARTIAL_TO: partial_to_reg <= cfg_wdata;
                CFG_LINK_TO:    link_to_reg    <= cfg_wdata;
                default:        partial_to_reg <= partial_to_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            disc_reg   <= 1'b0;
            idle_reg   <= '0;
            tvalid_reg <= 1'b0;
            conn_reg   <= 1'b0;
            ever_reg   <= 1'b0;
            sil_reg    <= '0;
            mask_reg   <= {KW_COUNT{1'b1}};
            pos_reg    <= '0;
            tsp_reg    <= 1'b0;
            fc_reg     <= FC_NONE;
        end
        else
        begin
            count_reg  <= count_next;
            disc_reg   <= disc_next;
            idle_reg   <= idle_next;
            tvalid_reg <= tvalid_next;
            conn_reg   <= conn_next;
            ever_reg   <= ever_next;
            sil_reg    <= sil_next;
            mask_reg   <= mask_next;
            pos_reg    <= pos_next;
            tsp_reg    <= tsp_next;
            fc_reg     <= fc_next;
        end
    end

    // The stored line never reaches the buffer size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(count_reg) < BUF_LIMIT)
        else $error("line count reached buffer size");

    // The link is only up once some byte has been received.
    a_conn_ever: assert property (@(posedge clk) disable iff (!rst_n)
        conn_reg |-> ever_reg)
        else $error("link up without any received byte");

    // A failsafe landing always takes the link down.
    a_failsafe_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res == EV_FAILSAFE) |=> !conn_reg)
        else $error("failsafe issued while link stays up");

endmodule

// ----- design/acl_out_stage.sv -----
// Result register of the command line receiver.
// Holds one result until taken or replaced by a load; uses acl_pkg.
module acl_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  acl_pkg::result_t res,
    output logic             out_valid,
    input  logic             out_ready,
    output acl_pkg::result_t out_res
);
    import acl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

// ----- design/ascii_command_line_receiver_core.sv -----
// ASCII command line receiver, top level.
// Input requests are received UART bytes or time ticks (tuser selects which).
// Each accepted byte other than CR or LF extends the current line; at LF a
// kept, non-empty line is matched against the five flight command keywords,
// or reported as a JSON line when it opens with a brace or bracket. Ticks age
// the line and the link; after link silence one failsafe landing request is
// issued per connection.
// Each input request gives zero or one output request, which is registered
// in the output register; one request is taken every cycle unless the output
// is stalled: the whole update runs between the input register and the output
// register. The timeouts are to be written through the cfg port while idle;
// the block itself does not enforce this.
// Reset clears the line, the link state and both stages, and loads the
// timeouts with 2000 and 1000 ticks. When the receiver stalls, the output
// register holds its request and the input register keeps the next one; the
// slave side is then stalled as well.
module ascii_command_line_receiver_core #(
    parameter int LINE_BUF_SIZE = acl_pkg::LINE_BUF_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] line_len, [7] link_up
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import acl_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.opcode  = opcode_t'(s_axis_tuser);
    assign in_item.rx_byte = s_axis_tdata;
    assign advance         = item_valid && (!m_axis_tvalid || m_axis_tready);

    acl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    acl_engine #(
        .LINE_BUF_SIZE (LINE_BUF_SIZE)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    acl_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tuser = out_res.event_res;
    assign m_axis_tdata = {out_res.link_up, out_res.line_len};

endmodule
